/* rtl/occupancy_grid_collision_query_defines.svh */
// Assertion macros for the occupancy grid collision query block.
// Included by files that check their own logic; no other dependencies.
`ifndef OCCUPANCY_GRID_COLLISION_QUERY_DEFINES_SVH
`define OCCUPANCY_GRID_COLLISION_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OGCQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OGCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ogcq_pkg.sv */
// Shared types and constants for the occupancy grid collision query block.
// No dependencies.
`timescale 1ns / 1ps

package ogcq_pkg;

    localparam int CELL_SHIFT = 4;
    localparam int GRID_BITS  = 8;
    localparam int WORD_BITS  = 16;
    localparam int WORD_SEL_W = 4;
    localparam int MAP_WORDS  = 4096;
    localparam int MAP_ADDR_W = 12;

    localparam logic [3:0] MAX_RANGE = 4'd15;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RECT  = 2'd1;
    localparam logic [1:0] OP_NEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_READ,
        ST_WR_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef logic signed [9:0] coord_t;

endpackage

/* rtl/ogcq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ogcq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/occupancy_grid_collision_query.sv */
// Top level of the occupancy grid collision query block.
// Depends on ogcq_pkg, ogcq_ram and occupancy_grid_collision_query_defines.svh.
//
// The block keeps a 256 x 256 bitmap of occupied cells in a RAM of 4096
// 16-bit words. Input transactions arrive on the s_ group; s_tuser carries
// the operation. A write sets or clears one cell with a read-modify-write
// and gives no result; the next input waits for its read and write states.
// A rectangle or near query walks its cells one RAM read per cycle and stops
// at the first occupied cell; m_tvalid then rises, and on a miss the walk
// ends with a drain state before it. A rectangle of zero width or height
// skips the walk and answers in the cycle after it is accepted.
// The single RAM read port sets the pace of the walk.
// Each query gives one transaction on the m_ group; the result is held while
// m_tready is low, and no new input is accepted until it is taken. The next
// input can be accepted in the cycle after that.
// After reset the block clears all 4096 words of the bitmap, one word per
// cycle; s_tready stays low during that sweep.
// Operation code 3 is accepted and dropped.
`timescale 1ns / 1ps
`include "occupancy_grid_collision_query_defines.svh"

module occupancy_grid_collision_query (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // From bit 0: pos_x[12], pos_y[12], size_w[12], size_h[12], search_range[4],
    // cell_col[8], cell_row[8], cell_value[1], zero padding[3].
    input  logic [71:0] s_tdata,
    // From bit 0: operation[2].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: hit[1], zero padding[7].
    output logic [7:0]  m_tdata
);

    ogcq_pkg::state_t state_reg, state_next;

    logic [ogcq_pkg::MAP_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    ogcq_pkg::coord_t col_reg, col_next, row_reg, row_next;
    ogcq_pkg::coord_t col_end_reg, col_end_next;
    ogcq_pkg::coord_t row_top_reg, row_top_next, row_end_reg, row_end_next;
    ogcq_pkg::coord_t cy_reg, cy_next;
    logic signed [5:0] dx_reg, dx_next;
    logic [3:0] r_reg, r_next;
    logic near_reg, near_next;
    logic pend_reg, pend_next;
    logic [ogcq_pkg::WORD_SEL_W-1:0] pend_bit_reg, pend_bit_next;
    logic hit_reg, hit_next;
    logic [ogcq_pkg::MAP_ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [ogcq_pkg::WORD_SEL_W-1:0] wr_bit_reg, wr_bit_next;
    logic wr_val_reg, wr_val_next;

    logic                            ram_we;
    logic [ogcq_pkg::MAP_ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ogcq_pkg::WORD_BITS-1:0]  ram_wdata, ram_rdata, ram_mod;

    logic [11:0] in_x, in_y, in_w, in_h;
    logic [3:0]  in_range;
    logic [7:0]  in_col, in_row;
    logic        in_val;
    logic        accept;

    logic [12:0] x_last, y_last, cx_sum, cy_sum;
    logic [7:0]  right_col, bottom_row;
    logic [3:0]  r_in;
    ogcq_pkg::coord_t cx_in, cy_in;

    logic in_grid, probe_hit, hit_now, row_last, col_last;
    logic signed [5:0] dx_inc, adx;
    logic [3:0] span;
    ogcq_pkg::coord_t span_c, new_top, new_end;

    assign in_x     = s_tdata[11:0];
    assign in_y     = s_tdata[23:12];
    assign in_w     = s_tdata[35:24];
    assign in_h     = s_tdata[47:36];
    assign in_range = s_tdata[51:48];
    assign in_col   = s_tdata[59:52];
    assign in_row   = s_tdata[67:60];
    assign in_val   = s_tdata[68];
    assign accept   = s_tvalid && s_tready;

    assign x_last     = {1'b0, in_x} + {1'b0, in_w} - 13'd1;
    assign y_last     = {1'b0, in_y} + {1'b0, in_h} - 13'd1;
    assign right_col  = x_last[12] ? 8'hFF : x_last[11:4];
    assign bottom_row = y_last[12] ? 8'hFF : y_last[11:4];
    assign cx_sum     = {1'b0, in_x} + {2'b00, in_w[11:1]};
    assign cy_sum     = {1'b0, in_y} + {2'b00, in_h[11:1]};
    assign cx_in      = ogcq_pkg::coord_t'({1'b0, cx_sum[12:ogcq_pkg::CELL_SHIFT]});
    assign cy_in      = ogcq_pkg::coord_t'({1'b0, cy_sum[12:ogcq_pkg::CELL_SHIFT]});
    assign r_in       = (in_range > ogcq_pkg::MAX_RANGE) ? ogcq_pkg::MAX_RANGE : in_range;

    assign in_grid   = (col_reg[9:8] == 2'b00) && (row_reg[9:8] == 2'b00);
    assign probe_hit = pend_reg && ram_rdata[pend_bit_reg];
    assign hit_now   = hit_reg || probe_hit;
    assign row_last  = (row_reg == row_end_reg);
    assign col_last  = (col_reg == col_end_reg);
    assign dx_inc    = dx_reg + 6'sd1;
    assign adx       = dx_inc[5] ? -dx_inc : dx_inc;
    assign span      = r_reg - adx[3:0];
    assign span_c    = ogcq_pkg::coord_t'({6'b000000, span});
    assign new_top   = near_reg ? cy_reg - span_c : row_top_reg;
    assign new_end   = near_reg ? cy_reg + span_c : row_end_reg;

    always_comb
    begin
        ram_mod = ram_rdata;
        ram_mod[wr_bit_reg] = wr_val_reg;
    end

    ogcq_ram #(
        .WIDTH(ogcq_pkg::WORD_BITS),
        .DEPTH(ogcq_pkg::MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ogcq_pkg::ST_CLEAR:
            begin
                if (&clr_addr_reg)
                begin
                    state_next = ogcq_pkg::ST_IDLE;
                end
            end
            ogcq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        ogcq_pkg::OP_WRITE: state_next = ogcq_pkg::ST_WR_READ;
                        ogcq_pkg::OP_RECT:
                        begin
                            if (in_w == 12'd0 || in_h == 12'd0)
                            begin
                                state_next = ogcq_pkg::ST_RESULT;
                            end
                            else
                            begin
                                state_next = ogcq_pkg::ST_SCAN;
                            end
                        end
                        ogcq_pkg::OP_NEAR:  state_next = ogcq_pkg::ST_SCAN;
                        default:            state_next = ogcq_pkg::ST_IDLE;
                    endcase
                end
            end
            ogcq_pkg::ST_WR_READ:  state_next = ogcq_pkg::ST_WR_WRITE;
            ogcq_pkg::ST_WR_WRITE: state_next = ogcq_pkg::ST_IDLE;
            ogcq_pkg::ST_SCAN:
            begin
                if (hit_now)
                begin
                    state_next = ogcq_pkg::ST_RESULT;
                end
                else if (row_last && col_last)
                begin
                    state_next = ogcq_pkg::ST_DRAIN;
                end
            end
            ogcq_pkg::ST_DRAIN:    state_next = ogcq_pkg::ST_RESULT;
            ogcq_pkg::ST_RESULT:
            begin
                if (m_tready)
                begin
                    state_next = ogcq_pkg::ST_IDLE;
                end
            end
            default:               state_next = ogcq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ogcq_pkg::ST_IDLE);
        m_tvalid  = (state_reg == ogcq_pkg::ST_RESULT);
        m_tdata   = {7'b0000000, hit_reg};
        ram_we    = (state_reg == ogcq_pkg::ST_CLEAR) || (state_reg == ogcq_pkg::ST_WR_WRITE);
        ram_waddr = (state_reg == ogcq_pkg::ST_CLEAR) ? clr_addr_reg : wr_addr_reg;
        ram_wdata = (state_reg == ogcq_pkg::ST_CLEAR) ? '0 : ram_mod;
        ram_raddr = (state_reg == ogcq_pkg::ST_WR_READ) ? wr_addr_reg
                                                        : {row_reg[7:0], col_reg[7:4]};
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        col_end_next  = col_end_reg;
        row_top_next  = row_top_reg;
        row_end_next  = row_end_reg;
        cy_next       = cy_reg;
        dx_next       = dx_reg;
        r_next        = r_reg;
        near_next     = near_reg;
        pend_next     = pend_reg;
        pend_bit_next = pend_bit_reg;
        hit_next      = hit_reg;
        wr_addr_next  = wr_addr_reg;
        wr_bit_next   = wr_bit_reg;
        wr_val_next   = wr_val_reg;
        case (state_reg)
            ogcq_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ogcq_pkg::ST_IDLE:
            begin
                pend_next    = 1'b0;
                hit_next     = 1'b0;
                wr_addr_next = {in_row, in_col[7:4]};
                wr_bit_next  = in_col[3:0];
                wr_val_next  = in_val;
                near_next    = (s_tuser == ogcq_pkg::OP_NEAR);
                r_next       = r_in;
                cy_next      = cy_in;
                dx_next      = -$signed({2'b00, r_in});
                if (s_tuser == ogcq_pkg::OP_NEAR)
                begin
                    col_next     = cx_in - ogcq_pkg::coord_t'({6'b000000, r_in});
                    col_end_next = cx_in + ogcq_pkg::coord_t'({6'b000000, r_in});
                    row_next     = cy_in;
                    row_top_next = cy_in;
                    row_end_next = cy_in;
                end
                else
                begin
                    col_next     = ogcq_pkg::coord_t'({2'b00, in_x[11:4]});
                    col_end_next = ogcq_pkg::coord_t'({2'b00, right_col});
                    row_next     = ogcq_pkg::coord_t'({2'b00, in_y[11:4]});
                    row_top_next = ogcq_pkg::coord_t'({2'b00, in_y[11:4]});
                    row_end_next = ogcq_pkg::coord_t'({2'b00, bottom_row});
                end
            end
            ogcq_pkg::ST_SCAN:
            begin
                hit_next      = hit_now;
                pend_next     = in_grid;
                pend_bit_next = col_reg[3:0];
                if (row_last)
                begin
                    col_next     = col_reg + 10'sd1;
                    dx_next      = dx_inc;
                    row_next     = new_top;
                    row_top_next = new_top;
                    row_end_next = new_end;
                end
                else
                begin
                    row_next = row_reg + 10'sd1;
                end
            end
            ogcq_pkg::ST_DRAIN:
            begin
                hit_next  = hit_now;
                pend_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ogcq_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        col_end_reg  <= col_end_next;
        row_top_reg  <= row_top_next;
        row_end_reg  <= row_end_next;
        cy_reg       <= cy_next;
        dx_reg       <= dx_next;
        r_reg        <= r_next;
        near_reg     <= near_next;
        pend_bit_reg <= pend_bit_next;
        hit_reg      <= hit_next;
        wr_addr_reg  <= wr_addr_next;
        wr_bit_reg   <= wr_bit_next;
        wr_val_reg   <= wr_val_next;
    end

    `OGCQ_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input accepted while a result is pending")
    `OGCQ_ASSERT_NEXT(a_empty_rect, accept && s_tuser == ogcq_pkg::OP_RECT && in_w == 12'd0, m_tvalid && !m_tdata[0], "zero-width rectangle did not answer miss")
    `OGCQ_ASSERT_NEXT(a_write_quiet, accept && s_tuser == ogcq_pkg::OP_WRITE, !m_tvalid && !s_tready, "write transaction produced a result")

endmodule

/* tb/occupancy_grid_collision_query_tb.sv */
// Self-checking testbench for the occupancy grid collision query block.
// Keeps its own copy of the cell bitmap and predicts the hit of every query.
// Depends on ogcq_pkg and occupancy_grid_collision_query.
`timescale 1ns / 1ps

module occupancy_grid_collision_query_tb;

    localparam int          CELL_PIX       = 16;
    localparam int          GRID_DIM       = 256;
    localparam int          REGION_CELLS   = 32;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          TAIL_CYCLES    = 40;
    localparam int          WATCHDOG_LIMIT = 300000;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] px;
        logic [11:0] py;
        logic [11:0] sw;
        logic [11:0] sh;
        logic [3:0]  rng;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        val;
    } grid_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ogcq_pkg::OP_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    bit occupied_cells [0:GRID_DIM*GRID_DIM-1];
    bit pending_hits [$];
    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    logic hold_req     = 1'b0;

    occupancy_grid_collision_query uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit cell_is_set(input int col, input int row);
        if (col < 0 || row < 0 || col >= GRID_DIM || row >= GRID_DIM)
            return 1'b0;
        return occupied_cells[row * GRID_DIM + col];
    endfunction

    function automatic bit rect_covers_occupied(input grid_item_t it);
        int left;
        int right;
        int top;
        int bottom;
        if (it.sw == 0 || it.sh == 0)
            return 1'b0;
        left   = int'(it.px) / CELL_PIX;
        top    = int'(it.py) / CELL_PIX;
        right  = (int'(it.px) + int'(it.sw) - 1) / CELL_PIX;
        bottom = (int'(it.py) + int'(it.sh) - 1) / CELL_PIX;
        if (right > GRID_DIM - 1)
            right = GRID_DIM - 1;
        if (bottom > GRID_DIM - 1)
            bottom = GRID_DIM - 1;
        for (int gx = left; gx <= right; gx++)
            for (int gy = top; gy <= bottom; gy++)
                if (cell_is_set(gx, gy))
                    return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit near_finds_occupied(input grid_item_t it);
        int r;
        int cx;
        int cy;
        int adx;
        int ady;
        r = (it.rng > ogcq_pkg::MAX_RANGE) ? int'(ogcq_pkg::MAX_RANGE) : int'(it.rng);
        cx = (int'(it.px) + int'(it.sw) / 2) / CELL_PIX;
        cy = (int'(it.py) + int'(it.sh) / 2) / CELL_PIX;
        for (int dx = -r; dx <= r; dx++)
        begin
            adx = (dx < 0) ? -dx : dx;
            for (int dy = -r; dy <= r; dy++)
            begin
                ady = (dy < 0) ? -dy : dy;
                if (adx + ady <= r && cell_is_set(cx + dx, cy + dy))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [11:0] random_size(input int max_pix);
        return 12'(1 + $urandom_range(max_pix - 1));
    endfunction

    function automatic grid_item_t random_grid_item(input int base_col, input int base_row);
        grid_item_t it;
        int kind;
        it = grid_item_t'({$urandom, $urandom, $urandom});
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            it.op  = ogcq_pkg::OP_WRITE;
            it.col = 8'(base_col + $urandom_range(REGION_CELLS - 1));
            it.row = 8'(base_row + $urandom_range(REGION_CELLS - 1));
        end
        else if (kind < 90)
        begin
            it.op = (kind < 65) ? ogcq_pkg::OP_RECT : ogcq_pkg::OP_NEAR;
            it.px = 12'(base_col * CELL_PIX + $urandom_range(REGION_CELLS * CELL_PIX - 1));
            it.py = 12'(base_row * CELL_PIX + $urandom_range(REGION_CELLS * CELL_PIX - 1));
            if ($urandom_range(9) == 0)
            begin
                it.sw = random_size(4095);
                it.sh = random_size(32);
                if ($urandom_range(1))
                    {it.sw, it.sh} = {it.sh, it.sw};
            end
            else if (it.op == ogcq_pkg::OP_RECT)
            begin
                it.sw = random_size(256);
                it.sh = random_size(256);
            end
            else
            begin
                it.sw = random_size(64);
                it.sh = random_size(64);
            end
        end
        else if (kind < 95)
        begin
            it.op = OP_UNUSED;
        end
        else
        begin
            // Anywhere on the grid, with rectangles kept a few rows tall.
            case ($urandom_range(2))
                0: it.op = ogcq_pkg::OP_WRITE;
                1: it.op = ogcq_pkg::OP_RECT;
                default: it.op = ogcq_pkg::OP_NEAR;
            endcase
            it.sw = random_size(4095);
            it.sh = random_size((it.op == ogcq_pkg::OP_RECT) ? 64 : 4095);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_item(input grid_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {3'b000, it.val, it.row, it.col, it.rng, it.sh, it.sw, it.py, it.px};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (it.op)
            ogcq_pkg::OP_WRITE:
                occupied_cells[int'(it.row) * GRID_DIM + int'(it.col)] = it.val;
            ogcq_pkg::OP_RECT:  pending_hits = {pending_hits, rect_covers_occupied(it)};
            ogcq_pkg::OP_NEAR:  pending_hits = {pending_hits, near_finds_occupied(it)};
            default:  ;
        endcase
    endtask

    task automatic send_write(input int col, input int row, input bit val);
        grid_item_t it;
        it = grid_item_t'({$urandom, $urandom, $urandom});
        it.op  = ogcq_pkg::OP_WRITE;
        it.col = 8'(col);
        it.row = 8'(row);
        it.val = val;
        send_item(it);
    endtask

    task automatic send_query(input logic [1:0] op, input int px, input int py,
                              input int sw, input int sh, input int rng);
        grid_item_t it;
        it = grid_item_t'({$urandom, $urandom, $urandom});
        it.op  = op;
        it.px  = 12'(px);
        it.py  = 12'(py);
        it.sw  = 12'(sw);
        it.sh  = 12'(sh);
        it.rng = 4'(rng);
        send_item(it);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        grid_item_t it;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_query(ogcq_pkg::OP_RECT, 0, 0, 4095, 4095, 0);
        send_query(ogcq_pkg::OP_NEAR, 2048, 2048, 1, 1, 15);
        send_write(0, 0, 1'b1);
        send_query(ogcq_pkg::OP_RECT, 0, 0, 1, 1, 0);
        send_query(ogcq_pkg::OP_RECT, 0, 0, 0, 16, 0);
        send_query(ogcq_pkg::OP_RECT, 0, 0, 16, 0, 0);
        send_query(ogcq_pkg::OP_RECT, 15, 15, 1, 1, 0);
        send_query(ogcq_pkg::OP_RECT, 16, 0, 4095, 1, 0);
        send_write(255, 255, 1'b1);
        send_query(ogcq_pkg::OP_RECT, 4095, 4095, 4095, 4095, 0);
        send_query(ogcq_pkg::OP_NEAR, 4095, 4095, 1, 1, 0);
        send_query(ogcq_pkg::OP_NEAR, 4095, 4095, 4095, 4095, 15);
        send_query(ogcq_pkg::OP_NEAR, 160, 80, 1, 1, 15);
        send_query(ogcq_pkg::OP_NEAR, 160, 80, 1, 1, 14);
        send_query(ogcq_pkg::OP_NEAR, 0, 0, 4095, 4095, 0);
        it = grid_item_t'({$urandom, $urandom, $urandom});
        it.op = OP_UNUSED;
        send_item(it);
        send_write(127, 127, 1'b1);
        send_query(ogcq_pkg::OP_NEAR, 0, 0, 4095, 4095, 0);
        send_write(0, 0, 1'b0);
        send_query(ogcq_pkg::OP_RECT, 0, 0, 1, 1, 0);
        send_query(ogcq_pkg::OP_RECT, 0, 0, 4095, 4095, 0);
        send_query(ogcq_pkg::OP_NEAR, 0, 0, 1, 1, 15);
        send_write(255, 0, 1'b1);
        send_query(ogcq_pkg::OP_RECT, 4080, 0, 15, 15, 0);
        send_query(ogcq_pkg::OP_NEAR, 4095, 0, 1, 1, 15);
        send_query(ogcq_pkg::OP_NEAR, 3840, 240, 1, 1, 15);
    endtask

    task automatic test_random(input int n_items, input int send_pct, input int stall_pct);
        grid_item_t it;
        int counted;
        int base_col;
        int base_row;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        counted  = 0;
        base_col = 0;
        base_row = 0;
        while (counted < n_items)
        begin
            if (counted % 40 == 0)
            begin
                case ($urandom_range(3))
                    0, 1: base_col = 0;
                    2: base_col = GRID_DIM - REGION_CELLS;
                    default: base_col = $urandom_range(GRID_DIM - REGION_CELLS);
                endcase
                case ($urandom_range(3))
                    0, 1: base_row = 0;
                    2: base_row = GRID_DIM - REGION_CELLS;
                    default: base_row = $urandom_range(GRID_DIM - REGION_CELLS);
                endcase
            end
            it = random_grid_item(base_col, base_row);
            send_item(it);
            if (it.op != OP_UNUSED)
                counted++;
        end
    endtask

    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 24; i++)
            send_item(random_grid_item(0, 0));
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        for (int i = 0; i < 20; i++)
            send_item(random_grid_item(0, 0));
        wait_results_drained();
        for (int i = 0; i < 20; i++)
            send_item(random_grid_item(0, 0));
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        bit want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                report_mismatch($sformatf("hit %0b with no query outstanding", m_tdata[0]));
            end
            else
            begin
                want = pending_hits.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("hit %0b, expected %0b", m_tdata[0], want));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(150, 0, 0);
        test_random(150, 67, 0);
        test_result_backpressure();
        test_random(150, 0, 67);
        test_drain_pause();
        test_random(150, 6, 6);
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
